// ===== hw/rtl/ctf_pkg.sv =====
package ctf_pkg;

	localparam int unsigned CordicStepsDefault = 16;
	localparam int unsigned AngleTableLen = 24;
	localparam logic [15:0] BlendReset = 16'd62259;
	// gyro step = 8192*(P/16375) + (16384*(P%16375) + 16375)/32750, P = |rate|*ms
	localparam logic [13:0] GyroDivOdd = 14'd16375;
	localparam logic [31:0] GyroRecipA = 32'd2148663945;
	localparam logic [28:0] GyroRecipB = 29'd268582994;

	function automatic logic [21:0] step_angle(input logic [4:0] idx);
		logic [21:0] r;
		begin
			case (idx)
				5'd0: r = 22'd2949120;
				5'd1: r = 22'd1740967;
				5'd2: r = 22'd919879;
				5'd3: r = 22'd466945;
				5'd4: r = 22'd234379;
				5'd5: r = 22'd117304;
				5'd6: r = 22'd58666;
				5'd7: r = 22'd29335;
				5'd8: r = 22'd14668;
				5'd9: r = 22'd7334;
				5'd10: r = 22'd3667;
				5'd11: r = 22'd1833;
				5'd12: r = 22'd917;
				5'd13: r = 22'd458;
				5'd14: r = 22'd229;
				5'd15: r = 22'd115;
				5'd16: r = 22'd57;
				5'd17: r = 22'd29;
				5'd18: r = 22'd14;
				5'd19: r = 22'd7;
				5'd20: r = 22'd4;
				5'd21: r = 22'd2;
				5'd22: r = 22'd1;
				default: r = 22'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		begin
			if (v > 50'sd2147483647) r = 32'sh7fffffff;
			else if (v < -50'sd2147483648) r = 32'sh80000000;
			else r = v[31:0];
			return r;
		end
	endfunction

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_SQ    = 8'b00000010,
		ST_SQRT  = 8'b00000100,
		ST_CORD  = 8'b00001000,
		ST_GYRO  = 8'b00010000,
		ST_DIV   = 8'b00100000,
		ST_BLEND = 8'b01000000,
		ST_OUT   = 8'b10000000
	} state_t;

endpackage

// ===== hw/rtl/ctf_sqrt.sv =====
module ctf_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output logic        done,
	output logic [15:0] root
);
	logic [15:0] res_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [17:0] trial;

	always_comb begin
		trial = {res_q, 2'b01};
	end

	logic [31:0] n_q;
	logic [33:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			acc_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[29:0], 2'b00};
			if ({acc_q[31:0], n_q[31:30]} >= {16'd0, trial}) begin
				acc_q <= {acc_q[31:0], n_q[31:30]} - {16'd0, trial};
				res_q <= {res_q[14:0], 1'b1};
			end else begin
				acc_q <= {acc_q[31:0], n_q[31:30]};
				res_q <= {res_q[14:0], 1'b0};
			end
		end
	end

	assign root = res_q;
endmodule

// ===== hw/rtl/ctf_cordic.sv =====
module ctf_cordic #(
	parameter int unsigned CORDIC_STEPS = ctf_pkg::CordicStepsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [16:0] y_in,
	input  logic [15:0]        x_in,
	output logic               done,
	output logic signed [23:0] angle
);
	localparam int unsigned Steps = (CORDIC_STEPS > ctf_pkg::AngleTableLen) ?
		ctf_pkg::AngleTableLen : CORDIC_STEPS;
	logic signed [33:0] x_q, y_q;
	logic signed [23:0] z_q;
	logic [4:0]         i_q;
	logic               busy_q;
	logic               zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(Steps - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= $signed({4'b0000, x_in, 14'd0});
			y_q <= $signed({{3{y_in[16]}}, y_in, 14'd0});
			z_q <= '0;
			zero_q <= (x_in == 16'd0) && (y_in == 17'sd0);
		end else if (busy_q) begin
			if (!y_q[33]) begin
				x_q <= x_q + (y_q >>> i_q);
				y_q <= y_q - (x_q >>> i_q);
				z_q <= z_q + $signed({2'b00, ctf_pkg::step_angle(i_q)});
			end else begin
				x_q <= x_q - (y_q >>> i_q);
				y_q <= y_q + (x_q >>> i_q);
				z_q <= z_q - $signed({2'b00, ctf_pkg::step_angle(i_q)});
			end
		end
	end

	// zero vector has no defined angle: report 0
	assign angle = zero_q ? 24'sd0 : z_q;
endmodule

// ===== hw/rtl/complementary_tilt_filter.sv =====
// Per axis the FSM runs a square step (ST_SQ), the square root (ST_SQRT) and the CORDIC (ST_CORD);
// then a gyro step per axis (ST_GYRO, ST_DIV), a blend per axis (ST_BLEND) and the output state (ST_OUT).
// A new sample is taken only in the idle state: in_stall is high until the FSM is idle,
// and a result not yet taken holds the next one in the output state.
// Reset (arst_n low, asynchronous): angles and integrals cleared, stored blend weight 62259.
module complementary_tilt_filter #(
	parameter int unsigned CORDIC_STEPS = ctf_pkg::CordicStepsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in_cfg,
	output logic               ready_cfg,
	input  logic [15:0]        blend_weight,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] acc_sample_x,
	input  logic signed [15:0] acc_sample_y,
	input  logic signed [15:0] acc_sample_z,
	input  logic signed [15:0] rate_sample_x,
	input  logic signed [15:0] rate_sample_y,
	input  logic [15:0]        elapsed_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] tilt_pitch,
	output logic signed [31:0] tilt_roll,
	output logic signed [31:0] gyro_only_pitch,
	output logic signed [31:0] gyro_only_roll
);
	ctf_pkg::state_t st_q;
	logic [15:0] alpha_q;
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
	logic [15:0] ms_q;
	logic ch_q;
	logic signed [31:0] pe_q, re_q, pi_q, ri_q;
	logic signed [23:0] accp_q, accr_q;
	logic signed [31:0] stp_q, str_q;
	logic [31:0] sq_q;
	logic sq_go_q, sq_done, co_start, co_done;
	logic [15:0] root;
	logic signed [23:0] angle;
	logic signed [16:0] cy;
	logic [15:0] mag_q;
	logic [31:0] p_q;
	logic [17:0] qa_q;
	logic [27:0] yq_q;
	logic [13:0] qc_q;
	logic neg_q;
	logic [1:0] k_q;
	logic [63:0] recip_a, recip_b;
	logic [31:0] qa_mul, div_rem;
	logic [30:0] q_mag;
	logic signed [31:0] step_val;

	assign ready_cfg = (st_q == ctf_pkg::ST_IDLE);
	assign in_stall = (st_q != ctf_pkg::ST_IDLE);
	assign cy = ch_q ? -{ax_q[15], ax_q} : {ay_q[15], ay_q};

	assign recip_a = {32'd0, p_q} * {32'd0, ctf_pkg::GyroRecipA};
	assign qa_mul = {14'd0, qa_q} * {18'd0, ctf_pkg::GyroDivOdd};
	assign div_rem = p_q - qa_mul;
	assign recip_b = {36'd0, yq_q} * {35'd0, ctf_pkg::GyroRecipB};
	assign q_mag = {qa_q, 13'd0} + {17'd0, qc_q};
	assign step_val = neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

	logic signed [31:0] x1, x2;
	always_comb begin
		x1 = ch_q ? 32'(signed'(ay_q)) : 32'(signed'(ax_q));
		x2 = 32'(signed'(az_q));
	end

	ctf_sqrt u_sqrt (.clk, .arst_n, .start(sq_go_q), .radicand(sq_q),
		.done(sq_done), .root);
	ctf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (.clk, .arst_n,
		.start(co_start), .y_in(cy), .x_in(mag_q), .done(co_done), .angle);

	logic signed [31:0] rate_sel;
	assign rate_sel = ch_q ? 32'(signed'(gy_q)) : 32'(signed'(gx_q));
	logic signed [49:0] bl_sum;
	logic signed [31:0] prev_sel, step_sel;
	logic signed [23:0] acc_sel;
	always_comb begin
		prev_sel = ch_q ? re_q : pe_q;
		step_sel = ch_q ? str_q : stp_q;
		acc_sel = ch_q ? accr_q : accp_q;
		bl_sum = $signed({1'b0, alpha_q}) * (50'(prev_sel) + 50'(step_sel))
			+ $signed({1'b0, 17'd65536 - {1'b0, alpha_q}}) * 50'(acc_sel)
			+ 50'sd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ctf_pkg::ST_IDLE;
			alpha_q <= ctf_pkg::BlendReset;
			pe_q <= '0; re_q <= '0; pi_q <= '0; ri_q <= '0;
			out_valid <= 1'b0;
			ch_q <= 1'b0;
			co_start <= 1'b0;
			sq_go_q <= 1'b0;
			k_q <= '0;
		end else begin
			co_start <= 1'b0;
			sq_go_q <= 1'b0;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				ctf_pkg::ST_IDLE: begin
					if (valid_in_cfg) alpha_q <= blend_weight;
					if (in_valid) begin
						ch_q <= 1'b0;
						st_q <= ctf_pkg::ST_SQ;
					end
				end
				ctf_pkg::ST_SQ: begin
					sq_go_q <= 1'b1;
					st_q <= ctf_pkg::ST_SQRT;
				end
				ctf_pkg::ST_SQRT: if (sq_done) begin
					co_start <= 1'b1;
					st_q <= ctf_pkg::ST_CORD;
				end
				ctf_pkg::ST_CORD: if (co_done) begin
					if (ch_q) begin
						ch_q <= 1'b0;
						st_q <= ctf_pkg::ST_GYRO;
					end else begin
						ch_q <= 1'b1;
						st_q <= ctf_pkg::ST_SQ;
					end
				end
				ctf_pkg::ST_GYRO: begin
					k_q <= '0;
					st_q <= ctf_pkg::ST_DIV;
				end
				ctf_pkg::ST_DIV: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						if (ch_q) begin
							ch_q <= 1'b0;
							st_q <= ctf_pkg::ST_BLEND;
						end else begin
							ch_q <= 1'b1;
							st_q <= ctf_pkg::ST_GYRO;
						end
					end
				end
				ctf_pkg::ST_BLEND: begin
					if (ch_q) begin
						re_q <= ctf_pkg::sat32(bl_sum >>> 16);
						ri_q <= ctf_pkg::sat32(50'(ri_q) + 50'(str_q));
						st_q <= ctf_pkg::ST_OUT;
					end else begin
						pe_q <= ctf_pkg::sat32(bl_sum >>> 16);
						pi_q <= ctf_pkg::sat32(50'(pi_q) + 50'(stp_q));
						ch_q <= 1'b1;
					end
				end
				ctf_pkg::ST_OUT: if (!out_valid) begin
					out_valid <= 1'b1;
					st_q <= ctf_pkg::ST_IDLE;
				end
				default: st_q <= ctf_pkg::ST_IDLE;
			endcase
		end
	end

	logic [31:0] abs_rate;
	assign abs_rate = rate_sel[31] ? 32'(-rate_sel) : rate_sel;

	always_ff @(posedge clk) begin
		if (st_q == ctf_pkg::ST_IDLE && in_valid) begin
			ax_q <= acc_sample_x; ay_q <= acc_sample_y; az_q <= acc_sample_z;
			gx_q <= rate_sample_x; gy_q <= rate_sample_y; ms_q <= elapsed_ms;
		end
		if (st_q == ctf_pkg::ST_SQ) sq_q <= 32'(x1 * x1) + 32'(x2 * x2);
		if (st_q == ctf_pkg::ST_SQRT && sq_done) mag_q <= root;
		if (st_q == ctf_pkg::ST_CORD && co_done) begin
			if (ch_q) accr_q <= angle;
			else accp_q <= angle;
		end
		if (st_q == ctf_pkg::ST_GYRO) begin
			p_q <= {16'd0, abs_rate[15:0]} * {16'd0, ms_q};
			neg_q <= rate_sel[31];
		end
		if (st_q == ctf_pkg::ST_DIV) begin
			if (k_q == 2'd0) qa_q <= recip_a[62:45];
			if (k_q == 2'd1) yq_q <= {div_rem[13:0], ctf_pkg::GyroDivOdd};
			if (k_q == 2'd2) qc_q <= recip_b[56:43];
			if (k_q == 2'd3) begin
				if (ch_q) str_q <= step_val;
				else stp_q <= step_val;
			end
		end
		if (st_q == ctf_pkg::ST_OUT && !out_valid) begin
			tilt_pitch <= pe_q; tilt_roll <= re_q;
			gyro_only_pitch <= pi_q; gyro_only_roll <= ri_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> st_q == ctf_pkg::ST_SQ) else $error("start");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("drop");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(tilt_pitch)) else $error("hold");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ctf_pkg::ST_DIV |-> in_stall) else $error("busy");
endmodule
